### design/scfb_pkg.sv
// shared types, constants and the ident text for the serial card frame bridge
// no dependencies
`default_nettype none

package scfb_pkg;

   localparam int FRAME_BYTES = 128;
   localparam int ADDR_W      = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
   localparam int COUNT_W     = 8;
   localparam int IDENT_LEN   = 7;
   localparam int IDX_W       = 3;

   localparam logic [7:0] OP_IDENT   = 8'hA0;
   localparam logic [7:0] OP_VER     = 8'hA1;
   localparam logic [7:0] OP_READ    = 8'hA2;
   localparam logic [7:0] OP_WRITE   = 8'hA3;
   localparam logic [7:0] OP_PORT    = 8'hA4;
   localparam logic [7:0] RSP_ERR    = 8'hE0;
   localparam logic [7:0] RSP_VER    = 8'h11;
   localparam logic [7:0] RSP_BADSUM = 8'h4E;

   typedef enum logic [1:0] {
      REQ_HOST        = 2'd0,
      REQ_CARD_DATA   = 2'd1,
      REQ_CARD_STATUS = 2'd2,
      REQ_CARD_FETCH  = 2'd3
   } req_kind_type;

   typedef enum logic [3:0] {
      PH_IDLE    = 4'd0,
      PH_PORT    = 4'd1,
      PH_RD_HI   = 4'd2,
      PH_RD_LO   = 4'd3,
      PH_RD_BUSY = 4'd4,
      PH_WR_HI   = 4'd5,
      PH_WR_LO   = 4'd6,
      PH_WR_DATA = 4'd7,
      PH_WR_SUM  = 4'd8,
      PH_WR_BUSY = 4'd9
   } phase_type;

   typedef enum logic [2:0] {
      BURST_ONE_HOST = 3'd0,
      BURST_TWO_HOST = 3'd1,
      BURST_IDENT    = 3'd2,
      BURST_CMD      = 3'd3,
      BURST_FETCH    = 3'd4
   } burst_kind_type;

   // everything the output stage needs to play back one input's results
   typedef struct packed {
      logic           load;
      burst_kind_type kind;
      logic [7:0]     byte0;
      logic [7:0]     byte1;
      logic           cmd_write;
      logic           slot;
      logic [15:0]    frame;
   } burst_type;

   function automatic logic [7:0] ident_char(input logic [IDX_W-1:0] i);
      logic [7:0] c;
      unique case (i)
         3'd0:    c = 8'h50;
         3'd1:    c = 8'h53;
         3'd2:    c = 8'h31;
         3'd3:    c = 8'h43;
         3'd4:    c = 8'h4C;
         3'd5:    c = 8'h4E;
         3'd6:    c = 8'h4B;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

### design/scfb_req_if.sv
// input channel of the bridge: valid/ready plus request type and byte
// depends on scfb_pkg for nothing; plain widths from the field list
`default_nettype none

interface scfb_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] req_type;
   logic [7:0] in_byte;

   modport source (output valid, output req_type, output in_byte, input ready);
   modport sink   (input valid, input req_type, input in_byte, output ready);
endinterface

`default_nettype wire

### design/scfb_rsp_if.sv
// result channel of the bridge: valid/ready plus the host and card fields
// plain widths from the field list
`default_nettype none

interface scfb_rsp_if;
   logic        valid;
   logic        ready;
   logic        host_valid;
   logic [7:0]  host_byte;
   logic        card_cmd_valid;
   logic        card_cmd_write;
   logic        card_slot;
   logic [15:0] card_frame;
   logic        card_byte_valid;
   logic [7:0]  card_byte;
   logic        last;

   modport source (output valid, output host_valid, output host_byte,
                   output card_cmd_valid, output card_cmd_write, output card_slot,
                   output card_frame, output card_byte_valid, output card_byte,
                   output last, input ready);
   modport sink   (input valid, input host_valid, input host_byte,
                   input card_cmd_valid, input card_cmd_write, input card_slot,
                   input card_frame, input card_byte_valid, input card_byte,
                   input last, output ready);
endinterface

`default_nettype wire

### design/scfb_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`default_nettype none

module scfb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  wire logic                                    clock,
   input  wire logic                                    wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                        wr_data,
   input  wire logic                                    rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

### design/scfb_ctrl.sv
// command decoder and phase machine; builds at most one burst per accepted word
// depends on scfb_pkg; drives the frame buffer ram ports
`default_nettype none

module scfb_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        accept,
   input  wire logic [1:0]                  req_type,
   input  wire logic [7:0]                  in_byte,
   output scfb_pkg::burst_type              burst,
   output logic                             ram_wr_en,
   output logic [scfb_pkg::ADDR_W-1:0]      ram_wr_addr,
   output logic [7:0]                       ram_wr_data,
   output logic                             ram_rd_en,
   output logic [scfb_pkg::ADDR_W-1:0]      ram_rd_addr
);
   import scfb_pkg::*;

   phase_type          phase_ff, phase_in;
   logic               slot_ff, slot_in;
   logic [15:0]        frame_ff, frame_in;
   logic [7:0]         xor_ff, xor_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               count_open;

   localparam logic [COUNT_W-1:0] FRAME_END  = COUNT_W'(FRAME_BYTES);
   localparam logic [COUNT_W-1:0] FRAME_LAST = COUNT_W'(FRAME_BYTES - 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         slot_ff  <= 1'b0;
         frame_ff <= '0;
         xor_ff   <= '0;
         count_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         slot_ff  <= slot_in;
         frame_ff <= frame_in;
         xor_ff   <= xor_in;
         count_ff <= count_in;
      end
   end

   assign count_open  = (count_ff < FRAME_END);
   assign ram_wr_addr = count_ff[ADDR_W-1:0];
   assign ram_rd_addr = count_ff[ADDR_W-1:0];
   assign ram_wr_data = in_byte;

   always_comb begin
      phase_in        = phase_ff;
      slot_in         = slot_ff;
      frame_in        = frame_ff;
      xor_in          = xor_ff;
      count_in        = count_ff;
      ram_wr_en       = 1'b0;
      ram_rd_en       = 1'b0;
      burst.load      = 1'b0;
      burst.kind      = BURST_ONE_HOST;
      burst.byte0     = in_byte;
      burst.byte1     = in_byte;
      burst.cmd_write = 1'b0;
      burst.slot      = slot_ff;
      burst.frame     = frame_ff;

      if (accept) begin
         unique case (req_kind_type'(req_type))
            REQ_HOST: begin
               unique case (phase_ff)
                  PH_IDLE: begin
                     unique case (in_byte)
                        OP_IDENT: begin
                           burst.load = 1'b1;
                           burst.kind = BURST_IDENT;
                        end
                        OP_VER: begin
                           burst.load  = 1'b1;
                           burst.byte0 = RSP_VER;
                        end
                        OP_PORT:  phase_in = PH_PORT;
                        OP_READ:  phase_in = PH_RD_HI;
                        OP_WRITE: phase_in = PH_WR_HI;
                        default: begin
                           burst.load  = 1'b1;
                           burst.byte0 = RSP_ERR;
                        end
                     endcase
                  end
                  PH_PORT: begin
                     // anything above one clamps to one
                     slot_in  = |in_byte;
                     phase_in = PH_IDLE;
                  end
                  PH_RD_HI: begin
                     frame_in = {in_byte, 8'h00};
                     phase_in = PH_RD_LO;
                  end
                  PH_WR_HI: begin
                     frame_in = {in_byte, 8'h00};
                     phase_in = PH_WR_LO;
                  end
                  PH_RD_LO: begin
                     frame_in        = {frame_ff[15:8], in_byte};
                     xor_in          = frame_ff[15:8] ^ in_byte;
                     count_in        = '0;
                     burst.load      = 1'b1;
                     burst.kind      = BURST_CMD;
                     burst.cmd_write = 1'b0;
                     burst.frame     = {frame_ff[15:8], in_byte};
                     phase_in        = PH_RD_BUSY;
                  end
                  PH_WR_LO: begin
                     frame_in = {frame_ff[15:8], in_byte};
                     xor_in   = frame_ff[15:8] ^ in_byte;
                     count_in = '0;
                     phase_in = PH_WR_DATA;
                  end
                  PH_WR_DATA: begin
                     ram_wr_en = 1'b1;
                     xor_in    = xor_ff ^ in_byte;
                     count_in  = count_ff + 1'b1;
                     if (count_ff == FRAME_LAST) begin
                        phase_in = PH_WR_SUM;
                     end
                  end
                  PH_WR_SUM: begin
                     burst.load = 1'b1;
                     if (in_byte == xor_ff) begin
                        count_in        = '0;
                        burst.kind      = BURST_CMD;
                        burst.cmd_write = 1'b1;
                        phase_in        = PH_WR_BUSY;
                     end else begin
                        burst.byte0 = RSP_BADSUM;
                        phase_in    = PH_IDLE;
                     end
                  end
                  // host words while the card is busy are dropped
                  default: ;
               endcase
            end
            REQ_CARD_DATA: begin
               if (phase_ff == PH_RD_BUSY && count_open) begin
                  xor_in     = xor_ff ^ in_byte;
                  count_in   = count_ff + 1'b1;
                  burst.load = 1'b1;
               end
            end
            REQ_CARD_STATUS: begin
               if (phase_ff == PH_RD_BUSY) begin
                  burst.load  = 1'b1;
                  burst.kind  = BURST_TWO_HOST;
                  burst.byte0 = xor_ff;
                  burst.byte1 = in_byte;
                  phase_in    = PH_IDLE;
               end else if (phase_ff == PH_WR_BUSY) begin
                  burst.load = 1'b1;
                  phase_in   = PH_IDLE;
               end
            end
            REQ_CARD_FETCH: begin
               if (phase_ff == PH_WR_BUSY && count_open) begin
                  // data comes out of the ram read register in the next cycle, along with the loaded burst
                  ram_rd_en  = 1'b1;
                  count_in   = count_ff + 1'b1;
                  burst.load = 1'b1;
                  burst.kind = BURST_FETCH;
               end
            end
            default: ;
         endcase
      end
   end

endmodule

`default_nettype wire

### design/scfb_out.sv
// result register and burst sequencer: plays out one to seven result words
// depends on scfb_pkg and scfb_rsp_if
`default_nettype none

module scfb_out (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire scfb_pkg::burst_type burst,
   input  wire logic [7:0]   fetch_byte,
   output logic              can_load,
   scfb_rsp_if.source        rsp
);
   import scfb_pkg::*;

   logic             busy_ff, busy_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   burst_type        desc_ff, desc_in;
   logic             is_last;
   logic             taken;

   localparam logic [IDX_W-1:0] IDENT_LAST = IDX_W'(IDENT_LEN - 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      desc_ff <= desc_in;
   end

   always_comb begin
      unique case (desc_ff.kind)
         BURST_IDENT:    is_last = (idx_ff == IDENT_LAST);
         BURST_TWO_HOST: is_last = (idx_ff != '0);
         default:        is_last = 1'b1;
      endcase
   end

   assign taken    = busy_ff && rsp.ready;
   assign can_load = !busy_ff || (rsp.ready && is_last);

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      desc_in = desc_ff;
      if (burst.load) begin
         busy_in = 1'b1;
         idx_in  = '0;
         desc_in = burst;
      end else if (taken) begin
         if (is_last) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
   end

   always_comb begin
      rsp.valid           = busy_ff;
      rsp.last            = is_last;
      rsp.host_valid      = 1'b0;
      rsp.host_byte       = 8'h00;
      rsp.card_cmd_valid  = 1'b0;
      rsp.card_cmd_write  = 1'b0;
      rsp.card_slot       = 1'b0;
      rsp.card_frame      = 16'h0000;
      rsp.card_byte_valid = 1'b0;
      rsp.card_byte       = 8'h00;
      unique case (desc_ff.kind)
         BURST_ONE_HOST: begin
            rsp.host_valid = 1'b1;
            rsp.host_byte  = desc_ff.byte0;
         end
         BURST_TWO_HOST: begin
            rsp.host_valid = 1'b1;
            rsp.host_byte  = (idx_ff == '0) ? desc_ff.byte0 : desc_ff.byte1;
         end
         BURST_IDENT: begin
            rsp.host_valid = 1'b1;
            rsp.host_byte  = ident_char(idx_ff);
         end
         BURST_CMD: begin
            rsp.card_cmd_valid = 1'b1;
            rsp.card_cmd_write = desc_ff.cmd_write;
            rsp.card_slot      = desc_ff.slot;
            rsp.card_frame     = desc_ff.frame;
         end
         BURST_FETCH: begin
            rsp.card_byte_valid = 1'b1;
            rsp.card_byte       = fetch_byte;
         end
         default: ;
      endcase
   end

endmodule

`default_nettype wire

### design/serial_card_frame_bridge_core.sv
// Serial card frame bridge, top level.
// Channels: req_ch carries one word per handshake (req_type selects a host byte,
// a card read data byte, a card status byte or a card fetch of the next write
// byte; in_byte is the byte). rsp_ch carries result words: a byte for the host,
// a card read or write command, or a buffered byte for the card; last marks the
// final word caused by one request word. Words that cause no result are taken
// and dropped silently.
// Latency: the first result of a request word is valid the cycle after it is
// accepted. Throughput: one request word per cycle while each causes at most
// one result and rsp_ch is ready; the ident command plays out 7 words and the
// read status 2, one per cycle, and req_ch stays not ready until the last of
// them is taken. The output burst register is the only rate limit.
// The 128-byte frame buffer is a ram with registered read; it needs no clearing.
// Reset (synchronous) returns to the idle command phase with port 0 and drops
// any result not yet taken. When rsp_ch stalls, the pending word holds and
// req_ch drops ready until the burst in the output register completes.
// Depends on scfb_pkg, scfb_req_if, scfb_rsp_if, scfb_ram, scfb_ctrl, scfb_out.
`default_nettype none

module serial_card_frame_bridge_core (
   input  wire logic  clock,
   input  wire logic  reset,
   scfb_req_if.sink   req_ch,
   scfb_rsp_if.source rsp_ch
);
   import scfb_pkg::*;

   burst_type         burst;
   logic              can_load;
   logic              accept;
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [7:0]        ram_wr_data;
   logic              ram_rd_en;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [7:0]        ram_rd_data;

   assign req_ch.ready = can_load;
   assign accept       = req_ch.valid && can_load;

   scfb_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req_type    (req_ch.req_type),
      .in_byte     (req_ch.in_byte),
      .burst       (burst),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr)
   );

   scfb_ram #(
      .WIDTH (8),
      .DEPTH (FRAME_BYTES)
   ) u_buffer (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   scfb_out u_out (
      .clock      (clock),
      .reset      (reset),
      .burst      (burst),
      .fetch_byte (ram_rd_data),
      .can_load   (can_load),
      .rsp        (rsp_ch)
   );

endmodule

`default_nettype wire

### dv/scfb_bridge_checker.sv
`timescale 1ns / 1ps
// scoreboard for the serial card frame bridge: tracks the command and card phases,
// predicts every result word and compares it with what leaves the block
// depends on scfb_pkg, scfb_req_if and scfb_rsp_if
module scfb_bridge_checker (
   input  logic clock,
   input  logic reset,
   scfb_req_if  req_mon,
   scfb_rsp_if  rsp_mon,
   output int   fail_count,
   output int   pending_words
);
   import scfb_pkg::*;

   typedef struct packed {
      logic        host_valid;
      logic [7:0]  host_byte;
      logic        cmd_valid;
      logic        cmd_write;
      logic        cmd_slot;
      logic [15:0] frame;
      logic        byte_valid;
      logic [7:0]  card_byte;
      logic        last;
   } bridge_word_type;

   localparam logic [55:0] IDENT_ASCII = "PS1CLNK";

   phase_type       bridge_phase;
   logic            port_slot;
   logic [15:0]     frame_index;
   logic [7:0]      frame_xor;
   logic [7:0]      byte_count;
   logic [7:0]      frame_store [FRAME_BYTES];
   bridge_word_type expected_words [$];
   bridge_word_type burst [IDENT_LEN];
   int              burst_len;
   int              errors = 0;

   task automatic add_word(input logic hv, input logic [7:0] hb, input logic cv,
                           input logic cw, input logic cs, input logic [15:0] cf,
                           input logic bv, input logic [7:0] cb);
      bridge_word_type w;
      w.host_valid = hv;
      w.host_byte  = hb;
      w.cmd_valid  = cv;
      w.cmd_write  = cw;
      w.cmd_slot   = cs;
      w.frame      = cf;
      w.byte_valid = bv;
      w.card_byte  = cb;
      w.last       = 1'b0;
      burst[burst_len] = w;
      burst_len++;
   endtask

   task automatic predict_bridge(input req_kind_type kind, input logic [7:0] b);
      burst_len = 0;
      case (kind)
         REQ_HOST: begin
            case (bridge_phase)
               PH_IDLE: begin
                  if (b == OP_IDENT) begin
                     for (int i = 0; i < IDENT_LEN; i++)
                        add_word(1'b1, IDENT_ASCII[55 - 8*i -: 8], 1'b0, 1'b0,
                                 1'b0, 16'h0, 1'b0, 8'h0);
                  end else if (b == OP_VER) begin
                     add_word(1'b1, RSP_VER, 1'b0, 1'b0, 1'b0, 16'h0, 1'b0, 8'h0);
                  end else if (b == OP_PORT) begin
                     bridge_phase = PH_PORT;
                  end else if (b == OP_READ) begin
                     bridge_phase = PH_RD_HI;
                  end else if (b == OP_WRITE) begin
                     bridge_phase = PH_WR_HI;
                  end else begin
                     add_word(1'b1, RSP_ERR, 1'b0, 1'b0, 1'b0, 16'h0, 1'b0, 8'h0);
                  end
               end
               PH_PORT: begin
                  // anything above one selects port one
                  port_slot    = (b > 8'd1) ? 1'b1 : b[0];
                  bridge_phase = PH_IDLE;
               end
               PH_RD_HI: begin
                  frame_index  = {b, 8'h00};
                  bridge_phase = PH_RD_LO;
               end
               PH_WR_HI: begin
                  frame_index  = {b, 8'h00};
                  bridge_phase = PH_WR_LO;
               end
               PH_RD_LO: begin
                  frame_index[7:0] = b;
                  frame_xor        = frame_index[15:8] ^ b;
                  byte_count       = 8'd0;
                  add_word(1'b0, 8'h0, 1'b1, 1'b0, port_slot, frame_index, 1'b0, 8'h0);
                  bridge_phase     = PH_RD_BUSY;
               end
               PH_WR_LO: begin
                  frame_index[7:0] = b;
                  frame_xor        = frame_index[15:8] ^ b;
                  byte_count       = 8'd0;
                  bridge_phase     = PH_WR_DATA;
               end
               PH_WR_DATA: begin
                  frame_store[byte_count] = b;
                  frame_xor  = frame_xor ^ b;
                  byte_count = byte_count + 8'd1;
                  if (byte_count >= FRAME_BYTES)
                     bridge_phase = PH_WR_SUM;
               end
               PH_WR_SUM: begin
                  if (b == frame_xor) begin
                     byte_count   = 8'd0;
                     add_word(1'b0, 8'h0, 1'b1, 1'b1, port_slot, frame_index, 1'b0, 8'h0);
                     bridge_phase = PH_WR_BUSY;
                  end else begin
                     add_word(1'b1, RSP_BADSUM, 1'b0, 1'b0, 1'b0, 16'h0, 1'b0, 8'h0);
                     bridge_phase = PH_IDLE;
                  end
               end
               default: ;  // card busy, host word dropped
            endcase
         end
         REQ_CARD_DATA: begin
            if (bridge_phase == PH_RD_BUSY && byte_count < FRAME_BYTES) begin
               frame_xor  = frame_xor ^ b;
               byte_count = byte_count + 8'd1;
               add_word(1'b1, b, 1'b0, 1'b0, 1'b0, 16'h0, 1'b0, 8'h0);
            end
         end
         REQ_CARD_STATUS: begin
            if (bridge_phase == PH_RD_BUSY) begin
               // checksum of what arrived so far, then the status
               add_word(1'b1, frame_xor, 1'b0, 1'b0, 1'b0, 16'h0, 1'b0, 8'h0);
               add_word(1'b1, b, 1'b0, 1'b0, 1'b0, 16'h0, 1'b0, 8'h0);
               bridge_phase = PH_IDLE;
            end else if (bridge_phase == PH_WR_BUSY) begin
               add_word(1'b1, b, 1'b0, 1'b0, 1'b0, 16'h0, 1'b0, 8'h0);
               bridge_phase = PH_IDLE;
            end
         end
         default: begin
            if (bridge_phase == PH_WR_BUSY && byte_count < FRAME_BYTES) begin
               add_word(1'b0, 8'h0, 1'b0, 1'b0, 1'b0, 16'h0, 1'b1, frame_store[byte_count]);
               byte_count = byte_count + 8'd1;
            end
         end
      endcase
      if (burst_len > 0) begin
         burst[burst_len - 1].last = 1'b1;
         for (int i = 0; i < burst_len; i++)
            expected_words.push_back(burst[i]);
      end
   endtask

   task automatic check_field(input string field, input logic [15:0] want, input logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      bridge_word_type got;
      bridge_word_type want;
      if (reset) begin
         bridge_phase = PH_IDLE;
         port_slot    = 1'b0;
         frame_index  = 16'h0;
         frame_xor    = 8'h0;
         byte_count   = 8'h0;
         expected_words.delete();
      end else begin
         // results first, so a word leaving at this edge never meets its own request
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.host_valid = rsp_mon.host_valid;
            got.host_byte  = rsp_mon.host_byte;
            got.cmd_valid  = rsp_mon.card_cmd_valid;
            got.cmd_write  = rsp_mon.card_cmd_write;
            got.cmd_slot   = rsp_mon.card_slot;
            got.frame      = rsp_mon.card_frame;
            got.byte_valid = rsp_mon.card_byte_valid;
            got.card_byte  = rsp_mon.card_byte;
            got.last       = rsp_mon.last;
            if (expected_words.size() == 0) begin
               $display("%0t: unexpected result word, expected none, actual %0h", $time, got);
               errors++;
            end else begin
               want = expected_words.pop_front();
               check_field("host_valid", 16'(want.host_valid), 16'(got.host_valid));
               check_field("host_byte", 16'(want.host_byte), 16'(got.host_byte));
               check_field("card_cmd_valid", 16'(want.cmd_valid), 16'(got.cmd_valid));
               check_field("card_cmd_write", 16'(want.cmd_write), 16'(got.cmd_write));
               check_field("card_slot", 16'(want.cmd_slot), 16'(got.cmd_slot));
               check_field("card_frame", want.frame, got.frame);
               check_field("card_byte_valid", 16'(want.byte_valid), 16'(got.byte_valid));
               check_field("card_byte", 16'(want.card_byte), 16'(got.card_byte));
               check_field("last", 16'(want.last), 16'(got.last));
            end
         end
         if (req_mon.valid && req_mon.ready)
            predict_bridge(req_kind_type'(req_mon.req_type), req_mon.in_byte);
      end
      fail_count    <= errors;
      pending_words <= expected_words.size();
   end

endmodule

### dv/serial_card_frame_bridge_core_tb.sv
`timescale 1ns / 1ps
// top of the bridge testbench: clock, reset, host/card word stimulus, result
// back-pressure, watchdog and verdict; depends on scfb_pkg, both channel
// interfaces, serial_card_frame_bridge_core and scfb_bridge_checker
module serial_card_frame_bridge_core_tb;
   import scfb_pkg::*;

   localparam int STALL_LIMIT  = 2000;
   localparam int RANDOM_WORDS = 110;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   pending_words;
   int   words_sent = 0;
   int   idle_cycles = 0;
   logic sender_calm = 1'b0;
   logic receiver_calm = 1'b0;
   logic full_read_done = 1'b0;
   logic full_write_done = 1'b0;

   scfb_req_if req_ch ();
   scfb_rsp_if rsp_ch ();

   serial_card_frame_bridge_core u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   scfb_bridge_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .fail_count    (fail_count),
      .pending_words (pending_words)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int draw_gap(input logic calm);
      return calm ? 0 : $urandom_range(0, 11);
   endfunction

   task automatic send_word(input req_kind_type kind, input logic [7:0] b);
      int gap;
      gap = draw_gap(sender_calm);
      if ($urandom_range(0, 15) == 0)
         sender_calm = !sender_calm;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.req_type <= kind;
      req_ch.in_byte  <= b;
      do @(posedge clock); while (!req_ch.ready);
      words_sent++;
   endtask

   // hold the sender off until every predicted word has come out
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_words != 0)
         @(posedge clock);
   endtask

   task automatic read_frame(input logic [15:0] idx, input int ndata);
      send_word(REQ_HOST, OP_READ);
      send_word(REQ_HOST, idx[15:8]);
      send_word(REQ_HOST, idx[7:0]);
      for (int i = 0; i < ndata; i++) begin
         // stray words while the card is busy reading
         if ($urandom_range(0, 7) == 0) begin
            if ($urandom_range(0, 1) == 0)
               send_word(REQ_HOST, 8'($urandom));
            else
               send_word(REQ_CARD_FETCH, 8'($urandom));
         end
         send_word(REQ_CARD_DATA, 8'($urandom));
      end
      send_word(REQ_CARD_STATUS, 8'($urandom));
   endtask

   task automatic write_frame(input logic [15:0] idx, input logic good_sum, input int nfetch);
      logic [7:0] sum;
      logic [7:0] b;
      send_word(REQ_HOST, OP_WRITE);
      send_word(REQ_HOST, idx[15:8]);
      send_word(REQ_HOST, idx[7:0]);
      sum = idx[15:8] ^ idx[7:0];
      for (int i = 0; i < FRAME_BYTES; i++) begin
         b   = 8'($urandom);
         sum = sum ^ b;
         send_word(REQ_HOST, b);
      end
      if (!good_sum)
         sum = sum ^ 8'($urandom_range(1, 255));
      send_word(REQ_HOST, sum);
      if (good_sum) begin
         for (int i = 0; i < nfetch; i++) begin
            if ($urandom_range(0, 7) == 0) begin
               if ($urandom_range(0, 1) == 0)
                  send_word(REQ_HOST, 8'($urandom));
               else
                  send_word(REQ_CARD_DATA, 8'($urandom));
            end
            send_word(REQ_CARD_FETCH, 8'($urandom));
         end
         send_word(REQ_CARD_STATUS, 8'($urandom));
      end
   endtask

   initial begin
      int         directed_words;
      int         count;
      logic       good;
      logic [7:0] b;
      req_ch.valid    <= 1'b0;
      req_ch.req_type <= REQ_HOST;
      req_ch.in_byte  <= 8'h00;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_word(REQ_HOST, OP_IDENT);
      send_word(REQ_HOST, OP_VER);
      send_word(REQ_HOST, 8'h00);
      send_word(REQ_HOST, 8'hFF);
      send_word(REQ_HOST, 8'hA5);
      // card words with no card operation running
      send_word(REQ_CARD_DATA, 8'hFF);
      send_word(REQ_CARD_STATUS, 8'h00);
      send_word(REQ_CARD_FETCH, 8'hFF);
      // port argument clamp, then both ports
      send_word(REQ_HOST, OP_PORT);
      send_word(REQ_HOST, 8'hFF);
      send_word(REQ_HOST, OP_PORT);
      send_word(REQ_HOST, 8'h00);
      send_word(REQ_HOST, OP_PORT);
      send_word(REQ_HOST, 8'h01);
      // status before the frame is complete, and before any data at all
      read_frame(16'hFFFF, 2);
      read_frame(16'h0000, 0);
      drain_results();
      directed_words = words_sent;

      while (words_sent - directed_words < RANDOM_WORDS || !full_read_done || !full_write_done) begin
         case ($urandom_range(0, 9))
            0: send_word(REQ_HOST, OP_IDENT);
            1: send_word(REQ_HOST, OP_VER);
            2: begin
               send_word(REQ_HOST, OP_PORT);
               if ($urandom_range(0, 1) == 0)
                  send_word(REQ_HOST, 8'($urandom_range(0, 1)));
               else
                  send_word(REQ_HOST, 8'($urandom));
            end
            3: begin
               // any host byte that does not open a multi-word command
               do b = 8'($urandom); while (b == OP_READ || b == OP_WRITE || b == OP_PORT);
               send_word(REQ_HOST, b);
            end
            4: send_word(req_kind_type'($urandom_range(1, 3)), 8'($urandom));
            5, 6: begin
               if ($urandom_range(0, 3) == 0)
                  count = $urandom_range(0, FRAME_BYTES - 1);
               else
                  count = FRAME_BYTES + $urandom_range(0, 3);
               read_frame(16'($urandom), count);
               if (count >= FRAME_BYTES)
                  full_read_done = 1'b1;
            end
            default: begin
               good = ($urandom_range(0, 3) != 0);
               if ($urandom_range(0, 3) == 0)
                  count = $urandom_range(0, FRAME_BYTES - 1);
               else
                  count = FRAME_BYTES + $urandom_range(0, 2);
               write_frame(16'($urandom), good, count);
               if (good && count >= FRAME_BYTES)
                  full_write_done = 1'b1;
            end
         endcase
         if ($urandom_range(0, 11) == 0)
            drain_results();
      end

      drain_results();
      repeat (24) @(posedge clock);
      if (fail_count == 0 && pending_words == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   // result side back-pressure, one draw per word
   initial begin
      int stall;
      rsp_ch.ready <= 1'b0;
      wait (reset == 1'b0);
      forever begin
         stall = draw_gap(receiver_calm);
         if ($urandom_range(0, 15) == 0)
            receiver_calm = !receiver_calm;
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
